### rtl/deadman_teleop_velocity_command_top_assert.svh
// ----------------------------------------------------------------------------
// Dead-man teleop velocity command: assertion macros
// Implication checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef DEADMAN_TELEOP_VELOCITY_COMMAND_TOP_ASSERT_SVH
`define DEADMAN_TELEOP_VELOCITY_COMMAND_TOP_ASSERT_SVH

// same-cycle implication
`define DTVC_ASSERT_SAME(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("dtvc: same-cycle check failed");

// next-cycle implication
`define DTVC_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("dtvc: next-cycle check failed");

`endif

### rtl/dtvc_pkg.sv
// ----------------------------------------------------------------------------
// Dead-man teleop velocity command: package
// Field widths, register indexes, codes and the controller/datapath links.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dtvc_pkg;

   localparam int BTN_W       = 11;
   localparam int AXIS_W      = 14;
   localparam int VEL_W       = 16;
   localparam int MAX_W       = 15;
   localparam int STEP_W      = 13;
   localparam int WD_W        = 8;
   localparam int PAD_W       = 2;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 15;
   localparam int REQ_TDATA_W = 40;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TDATA_W = 32;
   localparam int RSP_TUSER_W = 1;

   localparam int PROD1_W     = STEP_W + MAX_W;
   localparam int PROD2_W     = PROD1_W + AXIS_W;
   localparam int FRAC_SHIFT  = 24;
   localparam int Q_W         = PROD2_W - FRAC_SHIFT;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_MAX_LIN   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_MAX_ANG   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_LIN_STEP  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_ANG_STEP  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_CANCEL_EN = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_WD_TICKS  = 3'd5;

   localparam logic [MAX_W-1:0]  RST_MAX_SPEED = 15'd2048;
   localparam logic [STEP_W-1:0] RST_STEP      = 13'd410;
   localparam logic [WD_W-1:0]   RST_WD_TICKS  = 8'd5;

   localparam logic OP_PAD  = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [PAD_W-1:0] PAD_ANALOG  = 2'd0;
   localparam logic [PAD_W-1:0] PAD_DIGITAL = 2'd1;

   localparam logic KIND_VEL    = 1'b0;
   localparam logic KIND_CANCEL = 1'b1;

   // button bits
   localparam int BTN_DEADMAN = 0;
   localparam int BTN_STOP    = 1;
   localparam int BTN_LEFT    = 2;
   localparam int BTN_RIGHT   = 3;
   localparam int BTN_UP      = 4;
   localparam int BTN_DOWN    = 5;
   localparam int BTN_LIN_UP  = 6;
   localparam int BTN_LIN_DN  = 7;
   localparam int BTN_ANG_UP  = 8;
   localparam int BTN_ANG_DN  = 9;
   localparam int BTN_CANCEL  = 10;

   localparam logic [STEP_W-1:0] SCALE_ONE   = 13'd4096;
   localparam logic [VEL_W:0]    VEL_POS_MAX = 17'd32767;
   localparam logic [VEL_W:0]    VEL_NEG_MAG = 17'd32768;

   // result source
   localparam logic [1:0] EMIT_NONE   = 2'd0;
   localparam logic [1:0] EMIT_ZERO   = 2'd1;
   localparam logic [1:0] EMIT_HELD   = 2'd2;
   localparam logic [1:0] EMIT_CANCEL = 2'd3;

   typedef struct packed {
      logic       load;
      logic       decode;
      logic       dig_inc;
      logic       dig_dec;
      logic       mul1;
      logic       mul1_ang;
      logic       mul2;
      logic       wr_lin;
      logic       wr_ang;
      logic [1:0] emit;
      logic       emit_last;
   } cmd_type;

   typedef struct packed {
      logic op;
      logic is_analog;
      logic is_digital;
      logic deadman;
      logic prev_deadman;
      logic alive;
      logic out_free;
      logic cancel_en;
      logic stop_edge;
      logic cancel_edge;
   } status_type;

endpackage

### rtl/dtvc_ctrl.sv
// ----------------------------------------------------------------------------
// Dead-man teleop velocity command: controller
// Sequences decode, digital steps, the shared multiplier and result emission.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtvc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  dtvc_pkg::status_type st,
   output dtvc_pkg::cmd_type    cmd
);
   import dtvc_pkg::*;

   localparam logic [3:0] S_IDLE          = 4'd0;
   localparam logic [3:0] S_DECODE        = 4'd1;
   localparam logic [3:0] S_DIG_INC       = 4'd2;
   localparam logic [3:0] S_DIG_DEC       = 4'd3;
   localparam logic [3:0] S_MUL0          = 4'd4;
   localparam logic [3:0] S_MUL1          = 4'd5;
   localparam logic [3:0] S_MUL2          = 4'd6;
   localparam logic [3:0] S_MUL3          = 4'd7;
   localparam logic [3:0] S_EMIT_HELD     = 4'd8;
   localparam logic [3:0] S_EMIT_ZERO     = 4'd9;
   localparam logic [3:0] S_EMIT_ZERO_PRE = 4'd10;
   localparam logic [3:0] S_EMIT_CANCEL   = 4'd11;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            if (st.op == OP_TICK) begin
               state_in = st.alive ? S_EMIT_HELD : S_IDLE;
            end else if (st.is_analog || st.is_digital) begin
               if (!st.deadman) begin
                  state_in = st.prev_deadman ? S_EMIT_ZERO : S_IDLE;
               end else if (st.is_analog) begin
                  state_in = S_MUL0;
               end else begin
                  state_in = S_DIG_INC;
               end
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DIG_INC: begin
            cmd.dig_inc = 1'b1;
            state_in    = S_DIG_DEC;
         end
         S_DIG_DEC: begin
            cmd.dig_dec = 1'b1;
            if (st.stop_edge) begin
               state_in = st.cancel_en ? S_EMIT_ZERO_PRE : S_EMIT_ZERO;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_MUL0: begin
            cmd.mul1 = 1'b1;
            state_in = S_MUL1;
         end
         S_MUL1: begin
            cmd.mul1     = 1'b1;
            cmd.mul1_ang = 1'b1;
            cmd.mul2     = 1'b1;
            state_in     = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul2   = 1'b1;
            cmd.wr_lin = 1'b1;
            state_in   = S_MUL3;
         end
         S_MUL3: begin
            cmd.wr_ang = 1'b1;
            state_in   = (st.cancel_edge && st.cancel_en) ? S_EMIT_CANCEL : S_IDLE;
         end
         S_EMIT_HELD: begin
            if (st.out_free) begin
               cmd.emit      = EMIT_HELD;
               cmd.emit_last = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_EMIT_ZERO: begin
            if (st.out_free) begin
               cmd.emit      = EMIT_ZERO;
               cmd.emit_last = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_EMIT_ZERO_PRE: begin
            if (st.out_free) begin
               cmd.emit = EMIT_ZERO;
               state_in = S_EMIT_CANCEL;
            end
         end
         S_EMIT_CANCEL: begin
            if (st.out_free) begin
               cmd.emit      = EMIT_CANCEL;
               cmd.emit_last = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/dtvc_datapath.sv
// ----------------------------------------------------------------------------
// Dead-man teleop velocity command: datapath
// Registers, watchdog, scales, held velocities, multiplier and result stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtvc_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [dtvc_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  logic [dtvc_pkg::REQ_TUSER_W-1:0]     req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [dtvc_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic [dtvc_pkg::RSP_TUSER_W-1:0]     rsp_tuser,
   output logic                                 rsp_tlast,
   input  logic                                 csr_we,
   input  logic [dtvc_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [dtvc_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  dtvc_pkg::cmd_type                    cmd,
   output dtvc_pkg::status_type                 st
);
   import dtvc_pkg::*;

   function automatic logic [STEP_W-1:0] sat_scale(input logic [STEP_W-1:0] v);
      return (v > SCALE_ONE) ? SCALE_ONE : v;
   endfunction

   function automatic logic [STEP_W-1:0] scale_up(input logic [STEP_W-1:0] s,
                                                  input logic [STEP_W-1:0] d);
      logic [STEP_W:0] sum;
      sum = {1'b0, s} + {1'b0, d};
      return (sum > {1'b0, SCALE_ONE}) ? SCALE_ONE : sum[STEP_W-1:0];
   endfunction

   function automatic logic [STEP_W-1:0] scale_dn(input logic [STEP_W-1:0] s,
                                                  input logic [STEP_W-1:0] d);
      return (s > d) ? (s - d) : '0;
   endfunction

   function automatic logic signed [VEL_W-1:0] clamp_hi(input logic signed [VEL_W-1:0] v,
                                                        input logic [STEP_W-1:0] d,
                                                        input logic [MAX_W-1:0] m);
      logic signed [VEL_W+1:0] sum;
      logic signed [VEL_W+1:0] lim;
      sum = {{2{v[VEL_W-1]}}, v} + {{(VEL_W+2-STEP_W){1'b0}}, d};
      lim = {{(VEL_W+2-MAX_W){1'b0}}, m};
      return (sum > lim) ? lim[VEL_W-1:0] : sum[VEL_W-1:0];
   endfunction

   function automatic logic signed [VEL_W-1:0] clamp_lo(input logic signed [VEL_W-1:0] v,
                                                        input logic [STEP_W-1:0] d,
                                                        input logic [MAX_W-1:0] m);
      logic signed [VEL_W+1:0] dif;
      logic signed [VEL_W+1:0] lim;
      dif = {{2{v[VEL_W-1]}}, v} - {{(VEL_W+2-STEP_W){1'b0}}, d};
      lim = -{{(VEL_W+2-MAX_W){1'b0}}, m};
      return (dif < lim) ? lim[VEL_W-1:0] : dif[VEL_W-1:0];
   endfunction

   // configuration
   logic [MAX_W-1:0]  max_lin_ff, max_lin_in, max_ang_ff, max_ang_in;
   logic [STEP_W-1:0] lin_step_ff, lin_step_in, ang_step_ff, ang_step_in;
   logic              cancel_en_ff, cancel_en_in;
   logic [WD_W-1:0]   wd_ticks_ff, wd_ticks_in;

   // block state
   logic                    alive_ff, alive_in;
   logic signed [VEL_W-1:0] held_lin_ff, held_lin_in, held_ang_ff, held_ang_in;
   logic [STEP_W-1:0]       lin_scale_ff, lin_scale_in, ang_scale_ff, ang_scale_in;
   logic [BTN_W-1:0]        prev_btn_ff, prev_btn_in;
   logic                    seen_ff, seen_in;
   logic [WD_W-1:0]         wd_left_ff, wd_left_in;
   logic [BTN_W-1:0]        edges_ff, edges_in;

   // item and arithmetic payload
   logic              op_ff;
   logic [PAD_W-1:0]  pad_kind_ff;
   logic [BTN_W-1:0]  btn_ff;
   logic [AXIS_W-1:0] lin_axis_ff, ang_axis_ff;
   logic [PROD1_W-1:0] prod1_ff, prod1_in;
   logic [AXIS_W-1:0]  mag_ff, mag_in;
   logic               neg1_ff, neg1_in;
   logic [PROD2_W-1:0] prod2_ff, prod2_in;
   logic               neg2_ff, neg2_in;

   // result stage
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_kind_ff, rsp_kind_in;
   logic [VEL_W-1:0]  rsp_lin_ff, rsp_lin_in, rsp_ang_ff, rsp_ang_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [BTN_W-1:0]        prev_eff, edges;
   logic [WD_W-1:0]         wd_next;
   logic [STEP_W-1:0]       sel_scale;
   logic [MAX_W-1:0]        sel_max;
   logic [AXIS_W-1:0]       sel_axis;
   logic [PROD2_W-1:0]      rnd;
   logic [Q_W-1:0]          q;
   logic [VEL_W:0]          q_sat, q_neg;
   logic signed [VEL_W-1:0] vel;

   assign prev_eff = seen_ff ? prev_btn_ff : btn_ff;
   assign edges    = btn_ff & ~prev_eff;
   assign wd_next  = (wd_left_ff != '0) ? (wd_left_ff - 1'b1) : '0;

   assign sel_scale = cmd.mul1_ang ? ang_scale_ff : lin_scale_ff;
   assign sel_max   = cmd.mul1_ang ? max_ang_ff   : max_lin_ff;
   assign sel_axis  = cmd.mul1_ang ? ang_axis_ff  : lin_axis_ff;

   assign rnd   = prod2_ff + (PROD2_W'(1) << (FRAC_SHIFT - 1));
   assign q     = rnd[PROD2_W-1:FRAC_SHIFT];
   assign q_sat = neg2_ff ? ((q > Q_W'(VEL_NEG_MAG)) ? VEL_NEG_MAG : q[VEL_W:0])
                          : ((q > Q_W'(VEL_POS_MAX)) ? VEL_POS_MAX : q[VEL_W:0]);
   assign q_neg = -q_sat;
   assign vel   = neg2_ff ? q_neg[VEL_W-1:0] : q_sat[VEL_W-1:0];

   always_comb begin
      max_lin_in   = max_lin_ff;
      max_ang_in   = max_ang_ff;
      lin_step_in  = lin_step_ff;
      ang_step_in  = ang_step_ff;
      cancel_en_in = cancel_en_ff;
      wd_ticks_in  = wd_ticks_ff;
      alive_in     = alive_ff;
      held_lin_in  = held_lin_ff;
      held_ang_in  = held_ang_ff;
      lin_scale_in = lin_scale_ff;
      ang_scale_in = ang_scale_ff;
      prev_btn_in  = prev_btn_ff;
      seen_in      = seen_ff;
      wd_left_in   = wd_left_ff;
      edges_in     = edges_ff;

      if (cmd.decode) begin
         if (op_ff == OP_TICK) begin
            wd_left_in = wd_next;
            if (alive_ff && (wd_next == '0)) begin
               alive_in     = 1'b0;
               held_lin_in  = '0;
               held_ang_in  = '0;
               lin_scale_in = sat_scale(lin_step_ff);
               ang_scale_in = sat_scale(ang_step_ff);
            end
         end else begin
            wd_left_in  = wd_ticks_ff;
            prev_btn_in = btn_ff;
            seen_in     = 1'b1;
            edges_in    = edges;
            if ((pad_kind_ff == PAD_ANALOG) || (pad_kind_ff == PAD_DIGITAL)) begin
               if (!btn_ff[BTN_DEADMAN]) begin
                  alive_in    = 1'b0;
                  held_lin_in = '0;
                  held_ang_in = '0;
                  if (prev_eff[BTN_DEADMAN] && (pad_kind_ff == PAD_ANALOG)) begin
                     lin_scale_in = sat_scale(lin_step_ff);
                     ang_scale_in = sat_scale(ang_step_ff);
                  end
               end else if (pad_kind_ff == PAD_ANALOG) begin
                  alive_in = 1'b1;
                  lin_scale_in = edges[BTN_LIN_UP] ? scale_up(lin_scale_ff, lin_step_ff)
                                                   : lin_scale_ff;
                  lin_scale_in = edges[BTN_LIN_DN] ? scale_dn(lin_scale_in, lin_step_ff)
                                                   : lin_scale_in;
                  ang_scale_in = edges[BTN_ANG_UP] ? scale_up(ang_scale_ff, ang_step_ff)
                                                   : ang_scale_ff;
                  ang_scale_in = edges[BTN_ANG_DN] ? scale_dn(ang_scale_in, ang_step_ff)
                                                   : ang_scale_in;
               end else begin
                  alive_in = 1'b1;
                  if (edges[BTN_STOP]) begin
                     held_lin_in = '0;
                     held_ang_in = '0;
                  end
               end
            end
         end
      end

      if (cmd.dig_inc) begin
         if (edges_ff[BTN_LEFT]) begin
            held_ang_in = clamp_hi(held_ang_ff, ang_step_ff, max_ang_ff);
         end
         if (edges_ff[BTN_UP]) begin
            held_lin_in = clamp_hi(held_lin_ff, lin_step_ff, max_lin_ff);
         end
      end
      if (cmd.dig_dec) begin
         if (edges_ff[BTN_RIGHT]) begin
            held_ang_in = clamp_lo(held_ang_ff, ang_step_ff, max_ang_ff);
         end
         if (edges_ff[BTN_DOWN]) begin
            held_lin_in = clamp_lo(held_lin_ff, lin_step_ff, max_lin_ff);
         end
      end
      if (cmd.wr_lin) begin
         held_lin_in = vel;
      end
      if (cmd.wr_ang) begin
         held_ang_in = vel;
      end

      if (csr_we) begin
         case (csr_addr)
            REG_MAX_LIN:   max_lin_in = csr_wdata[MAX_W-1:0];
            REG_MAX_ANG:   max_ang_in = csr_wdata[MAX_W-1:0];
            REG_LIN_STEP: begin
               lin_step_in  = csr_wdata[STEP_W-1:0];
               lin_scale_in = sat_scale(csr_wdata[STEP_W-1:0]);
            end
            REG_ANG_STEP: begin
               ang_step_in  = csr_wdata[STEP_W-1:0];
               ang_scale_in = sat_scale(csr_wdata[STEP_W-1:0]);
            end
            REG_CANCEL_EN: cancel_en_in = csr_wdata[0];
            REG_WD_TICKS:  wd_ticks_in  = csr_wdata[WD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // shared two-stage multiplier
   always_comb begin
      prod1_in = prod1_ff;
      mag_in   = mag_ff;
      neg1_in  = neg1_ff;
      prod2_in = prod2_ff;
      neg2_in  = neg2_ff;
      if (cmd.mul1) begin
         prod1_in = {{MAX_W{1'b0}}, sel_scale} * {{STEP_W{1'b0}}, sel_max};
         neg1_in  = sel_axis[AXIS_W-1];
         mag_in   = sel_axis[AXIS_W-1] ? (~sel_axis + 1'b1) : sel_axis;
      end
      if (cmd.mul2) begin
         prod2_in = {{AXIS_W{1'b0}}, prod1_ff} * {{PROD1_W{1'b0}}, mag_ff};
         neg2_in  = neg1_ff;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_lin_in   = rsp_lin_ff;
      rsp_ang_in   = rsp_ang_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.emit != EMIT_NONE) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = (cmd.emit == EMIT_CANCEL) ? KIND_CANCEL : KIND_VEL;
         rsp_lin_in   = (cmd.emit == EMIT_HELD) ? held_lin_ff : '0;
         rsp_ang_in   = (cmd.emit == EMIT_HELD) ? held_ang_ff : '0;
         rsp_last_in  = cmd.emit_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_lin_ff   <= RST_MAX_SPEED;
         max_ang_ff   <= RST_MAX_SPEED;
         lin_step_ff  <= RST_STEP;
         ang_step_ff  <= RST_STEP;
         cancel_en_ff <= 1'b0;
         wd_ticks_ff  <= RST_WD_TICKS;
         alive_ff     <= 1'b0;
         held_lin_ff  <= '0;
         held_ang_ff  <= '0;
         lin_scale_ff <= RST_STEP;
         ang_scale_ff <= RST_STEP;
         prev_btn_ff  <= '0;
         seen_ff      <= 1'b0;
         wd_left_ff   <= '0;
         edges_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         max_lin_ff   <= max_lin_in;
         max_ang_ff   <= max_ang_in;
         lin_step_ff  <= lin_step_in;
         ang_step_ff  <= ang_step_in;
         cancel_en_ff <= cancel_en_in;
         wd_ticks_ff  <= wd_ticks_in;
         alive_ff     <= alive_in;
         held_lin_ff  <= held_lin_in;
         held_ang_ff  <= held_ang_in;
         lin_scale_ff <= lin_scale_in;
         ang_scale_ff <= ang_scale_in;
         prev_btn_ff  <= prev_btn_in;
         seen_ff      <= seen_in;
         wd_left_ff   <= wd_left_in;
         edges_ff     <= edges_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff       <= req_tuser[0];
         pad_kind_ff <= req_tuser[PAD_W:1];
         btn_ff      <= req_tdata[BTN_W-1:0];
         lin_axis_ff <= req_tdata[BTN_W+AXIS_W-1:BTN_W];
         ang_axis_ff <= req_tdata[BTN_W+2*AXIS_W-1:BTN_W+AXIS_W];
      end
      prod1_ff    <= prod1_in;
      mag_ff      <= mag_in;
      neg1_ff     <= neg1_in;
      prod2_ff    <= prod2_in;
      neg2_ff     <= neg2_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_lin_ff  <= rsp_lin_in;
      rsp_ang_ff  <= rsp_ang_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign st.op           = op_ff;
   assign st.is_analog    = (pad_kind_ff == PAD_ANALOG);
   assign st.is_digital   = (pad_kind_ff == PAD_DIGITAL);
   assign st.deadman      = btn_ff[BTN_DEADMAN];
   assign st.prev_deadman = prev_eff[BTN_DEADMAN];
   assign st.alive        = alive_ff;
   assign st.out_free     = !rsp_valid_ff || rsp_tready;
   assign st.cancel_en    = cancel_en_ff;
   assign st.stop_edge    = edges_ff[BTN_STOP];
   assign st.cancel_edge  = edges_ff[BTN_CANCEL];

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ang_ff, rsp_lin_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

### rtl/deadman_teleop_velocity_command_top.sv
// ----------------------------------------------------------------------------
// Dead-man teleop velocity command: top level
// Joystick reports and ticks in, velocity and goal-cancel items out.
//
//   channel  direction  carries
//   req_*    in         tuser {pad_kind, op}; tdata {pad, ang_axis, lin_axis, buttons}
//   rsp_*    out        tuser {kind}; tdata {ang_vel, lin_vel}; tlast last
//   csr_*    in         write enable, register index, data
//
// Each item is first decoded; a digital report then steps its held velocities,
// an analog report passes through the shared two-stage multiplier, and results
// leave through the one-result output register.
// Reset is synchronous; control and configuration registers return to defaults.
// A stalled result holds in the output register while the next item is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module deadman_teleop_velocity_command_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // buttons, lin_axis, ang_axis, zero pad
   input  logic [dtvc_pkg::REQ_TDATA_W-1:0] req_tdata,
   // op, pad_kind
   input  logic [dtvc_pkg::REQ_TUSER_W-1:0] req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // lin_vel, ang_vel
   output logic [dtvc_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // kind
   output logic [dtvc_pkg::RSP_TUSER_W-1:0] rsp_tuser,
   output logic                             rsp_tlast,
   input  logic                             csr_we,
   input  logic [dtvc_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [dtvc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import dtvc_pkg::*;

   cmd_type    cmd;
   status_type st;

   dtvc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   dtvc_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .st         (st)
   );

endmodule

### rtl/dtvc_checker.sv
// ----------------------------------------------------------------------------
// Dead-man teleop velocity command: port checker
// Watches the result channel of the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "deadman_teleop_velocity_command_top_assert.svh"

module dtvc_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [dtvc_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [dtvc_pkg::RSP_TUSER_W-1:0] rsp_tuser,
   input logic                             rsp_tlast
);
   import dtvc_pkg::*;

   `DTVC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
   `DTVC_ASSERT_SAME(a_cancel_zero, clock, reset, rsp_tvalid && (rsp_tuser == KIND_CANCEL), (rsp_tdata == '0) && rsp_tlast)
   `DTVC_ASSERT_SAME(a_early_zero, clock, reset, rsp_tvalid && !rsp_tlast, (rsp_tuser == KIND_VEL) && (rsp_tdata == '0))
   `DTVC_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_tvalid)

endmodule

bind deadman_teleop_velocity_command_top dtvc_checker u_dtvc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
